### sv/aff3x4_pkg.sv
// Shared types and constants for the affine 3x4 matrix inverse core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package aff3x4_pkg;

  // Default fixed-point format: Q16.16 in a 32-bit word.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // One matrix transaction carries twelve elements, row by row.
  localparam int NUM_ELEMS = 12;

  // Row codes of the inverse.
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  // Control word that travels with every pipeline stage.
  typedef struct packed {
    logic       vld;
    logic [1:0] row;
  } aff_ctl_t;

endpackage

### sv/aff3x4_seq.sv
// Input register and row sequencer: holds one matrix and issues its three rows.
// Depends on aff3x4_pkg.
`timescale 1ns / 1ps

module aff3x4_seq #(
  parameter int WORD_BITS = aff3x4_pkg::WORD_BITS_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  adv_i,
  input  logic                                                  in_valid_i,
  output logic                                                  in_stall_o,
  input  logic [aff3x4_pkg::NUM_ELEMS-1:0][WORD_BITS-1:0]       elem_i,
  output logic [aff3x4_pkg::NUM_ELEMS-1:0][WORD_BITS-1:0]       elem_o,
  output aff3x4_pkg::aff_ctl_t                                  ctl_o
);
  import aff3x4_pkg::*;

  logic                                  busy_q;
  logic [1:0]                            row_q;
  logic [NUM_ELEMS-1:0][WORD_BITS-1:0]   elem_q;
  logic                                  accept;

  // A new matrix may enter in the cycle the last row of the current one leaves.
  assign in_stall_o = busy_q && !(adv_i && (row_q == ROW_LAST));
  assign accept     = in_valid_i && !in_stall_o;

  // Row counter and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= ROW_FIRST;
    end else if (accept) begin
      busy_q <= 1'b1;
      row_q  <= ROW_FIRST;
    end else if (adv_i && busy_q) begin
      if (row_q == ROW_LAST) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // Matrix holding register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_q <= elem_i;
    end
  end

  assign elem_o = elem_q;
  assign ctl_o  = '{vld: busy_q, row: row_q};

endmodule

### sv/aff3x4_cof.sv
// Cofactor and determinant stages: one row of the adjugate plus the exact
// determinant per row transaction, in four register stages. Depends on aff3x4_pkg.
`timescale 1ns / 1ps

module aff3x4_cof #(
  parameter int WORD_BITS = aff3x4_pkg::WORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             adv_i,
  input  aff3x4_pkg::aff_ctl_t                             ctl_i,
  input  logic [aff3x4_pkg::NUM_ELEMS-1:0][WORD_BITS-1:0]  elem_i,
  output aff3x4_pkg::aff_ctl_t                             ctl_o,
  output logic signed [2*WORD_BITS:0]                      cof_o [3],
  output logic signed [3*WORD_BITS+2:0]                    det_o,
  output logic signed [WORD_BITS-1:0]                      xl_o [3]
);
  import aff3x4_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic signed [W-1:0]  m  [3][3];
  logic signed [W-1:0]  mp [3][3];
  logic signed [PW-1:0] pa_d [3];
  logic signed [PW-1:0] pb_d [3];
  logic signed [PW-1:0] da_d [3];
  logic signed [PW-1:0] db_d [3];

  // Stage 1 registers.
  aff_ctl_t             c1_q;
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [PW-1:0] da_q [3];
  logic signed [PW-1:0] db_q [3];
  logic signed [W-1:0]  m0_1_q [3];
  logic signed [W-1:0]  xl1_q [3];
  // Stage 2 registers.
  aff_ctl_t             c2_q;
  logic signed [CW-1:0] cof2_q [3];
  logic signed [CW-1:0] dc2_q [3];
  logic signed [W-1:0]  m0_2_q [3];
  logic signed [W-1:0]  xl2_q [3];
  // Stage 3 registers.
  aff_ctl_t             c3_q;
  logic signed [CW-1:0] cof3_q [3];
  logic signed [CW-1:0] plo_d [3];
  logic signed [CW-1:0] phi_d [3];
  logic signed [CW-1:0] plo_q [3];
  logic signed [CW-1:0] phi_q [3];
  logic signed [W-1:0]  xl3_q [3];
  // Stage 4 registers.
  aff_ctl_t             c4_q;
  logic signed [CW-1:0] cof4_q [3];
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det4_q;
  logic signed [W-1:0]  xl4_q [3];

  // Unpack the matrix and rotate its columns so that the wanted adjugate
  // row always sits at fixed operand positions.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m[r][k] = $signed(elem_i[4*r+k]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        case (ctl_i.row)
          ROW_MID:  mp[r][k] = m[r][(k+1)%3];
          ROW_LAST: mp[r][k] = m[r][(k+2)%3];
          default:  mp[r][k] = m[r][k];
        endcase
      end
    end
  end

  // Products for the adjugate row and for the first adjugate column.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pa_d[j] = PW'(mp[(j+1)%3][1]) * PW'(mp[(j+2)%3][2]);
      pb_d[j] = PW'(mp[(j+1)%3][2]) * PW'(mp[(j+2)%3][1]);
      da_d[j] = PW'(m[1][(j+1)%3]) * PW'(m[2][(j+2)%3]);
      db_d[j] = PW'(m[1][(j+2)%3]) * PW'(m[2][(j+1)%3]);
    end
  end

  // Determinant partial products: the cofactor is split into a signed high
  // half and an unsigned low half so each multiply stays one word wide.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plo_d[k] = CW'(m0_2_q[k]) * CW'($signed({1'b0, dc2_q[k][W-1:0]}));
      phi_d[k] = CW'(m0_2_q[k]) * CW'($signed(dc2_q[k][CW-1:W]));
    end
    det_d = DW'(plo_q[0]) + DW'(plo_q[1]) + DW'(plo_q[2])
          + (DW'(phi_q[0]) <<< W) + (DW'(phi_q[1]) <<< W) + (DW'(phi_q[2]) <<< W);
  end

  // Control of all four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (adv_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // Data of all four stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        pa_q[j]   <= pa_d[j];
        pb_q[j]   <= pb_d[j];
        da_q[j]   <= da_d[j];
        db_q[j]   <= db_d[j];
        m0_1_q[j] <= m[0][j];
        xl1_q[j]  <= $signed(elem_i[4*j+3]);

        cof2_q[j] <= CW'(pa_q[j]) - CW'(pb_q[j]);
        dc2_q[j]  <= CW'(da_q[j]) - CW'(db_q[j]);
        m0_2_q[j] <= m0_1_q[j];
        xl2_q[j]  <= xl1_q[j];

        cof3_q[j] <= cof2_q[j];
        plo_q[j]  <= plo_d[j];
        phi_q[j]  <= phi_d[j];
        xl3_q[j]  <= xl2_q[j];

        cof4_q[j] <= cof3_q[j];
        xl4_q[j]  <= xl3_q[j];
      end
      det4_q <= det_d;
    end
  end

  assign ctl_o  = c4_q;
  assign cof_o  = cof4_q;
  assign det_o  = det4_q;
  assign xl_o   = xl4_q;

endmodule

### sv/aff3x4_div.sv
// Divider pipeline: three restoring dividers side by side, one quotient bit
// per stage, then rounding and saturation. Depends on aff3x4_pkg.
`timescale 1ns / 1ps

module aff3x4_div #(
  parameter int WORD_BITS = aff3x4_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = aff3x4_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  aff3x4_pkg::aff_ctl_t          ctl_i,
  input  logic signed [2*WORD_BITS:0]   cof_i [3],
  input  logic signed [3*WORD_BITS+2:0] det_i,
  input  logic signed [WORD_BITS-1:0]   xl_i [3],
  output aff3x4_pkg::aff_ctl_t          ctl_o,
  output logic                          sing_o,
  output logic signed [WORD_BITS-1:0]   ele_o [3],
  output logic signed [WORD_BITS-1:0]   xl_o [3]
);
  import aff3x4_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int NA  = 2 * W + 2 * FRAC_BITS;
  localparam int DB  = 3 * W;
  localparam int QB  = W;
  localparam int RW0 = (NA > DB + QB) ? NA : DB + QB;
  localparam int RW  = RW0 + 1;
  localparam logic [W:0]   HALF_M = (W+1)'(1) << (W - 1);
  localparam logic [W:0]   MAXP_M = HALF_M - (W+1)'(1);
  localparam logic [W-1:0] MAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W  = {1'b1, {(W-1){1'b0}}};

  // Magnitude stage.
  logic [CW-1:0]       cabs [3];
  logic [DW-1:0]       dabs;
  aff_ctl_t            ca_q;
  logic [NA-1:0]       a_q [3];
  logic [DB-1:0]       ba_q;
  logic                nega_q [3];
  logic                singa_q;
  logic signed [W-1:0] xla_q [3];

  // Bit stages; index 0 holds the overflow check and the start remainder.
  aff_ctl_t            ctl_d [QB+1];
  aff_ctl_t            ctl_q [QB+1];
  logic [RW-1:0]       rem_d [QB+1][3];
  logic [RW-1:0]       rem_q [QB+1][3];
  logic [QB-1:0]       quo_d [QB+1][3];
  logic [QB-1:0]       quo_q [QB+1][3];
  logic                ovf_d [QB+1][3];
  logic                ovf_q [QB+1][3];
  logic                neg_d [QB+1][3];
  logic                neg_q [QB+1][3];
  logic [DB-1:0]       b_d [QB+1];
  logic [DB-1:0]       b_q [QB+1];
  logic                sing_d [QB+1];
  logic                sing_q [QB+1];
  logic signed [W-1:0] xl_d [QB+1][3];
  logic signed [W-1:0] xl_q [QB+1][3];

  // Rounding and output stages.
  aff_ctl_t            cr_q;
  logic [W:0]          mag_q [3];
  logic                ovfr_q [3];
  logic                negr_q [3];
  logic                singr_q;
  logic signed [W-1:0] xlr_q [3];
  aff_ctl_t            co_q;
  logic signed [W-1:0] e_q [3];
  logic                singo_q;
  logic signed [W-1:0] xlo_q [3];

  logic [RW-1:0]       bsh;

  // Absolute values of numerator and divisor.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cabs[j] = cof_i[j][CW-1] ? CW'(-cof_i[j]) : CW'(cof_i[j]);
    end
    dabs = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
  end

  // Overflow check, then one restoring step per stage.
  always_comb begin
    bsh = '0;
    for (int j = 0; j < 3; j++) begin
      rem_d[0][j] = RW'(a_q[j]);
      quo_d[0][j] = '0;
      ovf_d[0][j] = RW'(a_q[j]) >= (RW'(ba_q) << QB);
      neg_d[0][j] = nega_q[j];
      xl_d[0][j]  = xla_q[j];
    end
    b_d[0]    = ba_q;
    sing_d[0] = singa_q;
    ctl_d[0]  = ca_q;
    for (int s = 0; s < QB; s++) begin
      for (int j = 0; j < 3; j++) begin
        bsh = RW'(b_q[s]) << (QB - 1 - s);
        quo_d[s+1][j] = quo_q[s][j];
        if (rem_q[s][j] >= bsh) begin
          rem_d[s+1][j] = rem_q[s][j] - bsh;
          quo_d[s+1][j][QB-1-s] = 1'b1;
        end else begin
          rem_d[s+1][j] = rem_q[s][j];
        end
        ovf_d[s+1][j] = ovf_q[s][j];
        neg_d[s+1][j] = neg_q[s][j];
        xl_d[s+1][j]  = xl_q[s][j];
      end
      b_d[s+1]    = b_q[s];
      sing_d[s+1] = sing_q[s];
      ctl_d[s+1]  = ctl_q[s];
    end
  end

  // Control registers of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q <= '0;
      cr_q <= '0;
      co_q <= '0;
      for (int s = 0; s <= QB; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (adv_i) begin
      ca_q <= ctl_i;
      for (int s = 0; s <= QB; s++) begin
        ctl_q[s] <= ctl_d[s];
      end
      cr_q <= ctl_q[QB];
      co_q <= cr_q;
    end
  end

  // Data registers: magnitudes, bit stages, rounding and saturation.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        a_q[j]    <= {cabs[j][2*W-1:0], {(2*FRAC_BITS){1'b0}}};
        nega_q[j] <= cof_i[j][CW-1] ^ det_i[DW-1];
        xla_q[j]  <= xl_i[j];
      end
      ba_q    <= dabs[DB-1:0];
      singa_q <= (det_i == '0);

      for (int s = 0; s <= QB; s++) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[s][j] <= rem_d[s][j];
          quo_q[s][j] <= quo_d[s][j];
          ovf_q[s][j] <= ovf_d[s][j];
          neg_q[s][j] <= neg_d[s][j];
          xl_q[s][j]  <= xl_d[s][j];
        end
        b_q[s]    <= b_d[s];
        sing_q[s] <= sing_d[s];
      end

      for (int j = 0; j < 3; j++) begin
        mag_q[j]  <= {1'b0, quo_q[QB][j]}
                   + (W+1)'({rem_q[QB][j][DB-1:0], 1'b0} >= {1'b0, b_q[QB]});
        ovfr_q[j] <= ovf_q[QB][j];
        negr_q[j] <= neg_q[QB][j];
        xlr_q[j]  <= xl_q[QB][j];
      end
      singr_q <= sing_q[QB];

      for (int j = 0; j < 3; j++) begin
        if (singr_q) begin
          e_q[j] <= '0;
        end else if (negr_q[j]) begin
          if (ovfr_q[j] || (mag_q[j] > HALF_M)) begin
            e_q[j] <= MIN_W;
          end else begin
            e_q[j] <= $signed(W'(-mag_q[j]));
          end
        end else begin
          if (ovfr_q[j] || (mag_q[j] > MAXP_M)) begin
            e_q[j] <= MAX_W;
          end else begin
            e_q[j] <= $signed(mag_q[j][W-1:0]);
          end
        end
        xlo_q[j] <= xlr_q[j];
      end
      singo_q <= singr_q;
    end
  end

  assign ctl_o  = co_q;
  assign sing_o = singo_q;
  assign ele_o  = e_q;
  assign xl_o   = xlo_q;

endmodule

### sv/aff3x4_xlat.sv
// Translation stages and output register: -(E * t) with rounding to the
// fraction grid and saturation. Depends on aff3x4_pkg.
`timescale 1ns / 1ps

module aff3x4_xlat #(
  parameter int WORD_BITS = aff3x4_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = aff3x4_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  aff3x4_pkg::aff_ctl_t        ctl_i,
  input  logic                        sing_i,
  input  logic signed [WORD_BITS-1:0] ele_i [3],
  input  logic signed [WORD_BITS-1:0] xl_i [3],
  output aff3x4_pkg::aff_ctl_t        ctl_o,
  output logic                        sing_o,
  output logic signed [WORD_BITS-1:0] ele_o [3],
  output logic signed [WORD_BITS-1:0] tr_o
);
  import aff3x4_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam logic [SW-1:0] RND    = SW'(1) << (FRAC_BITS - 1);
  localparam logic [SW-1:0] HALF_S = SW'(1) << (W - 1);
  localparam logic [SW-1:0] MAXP_S = HALF_S - SW'(1);
  localparam logic [W-1:0]  MAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_W  = {1'b1, {(W-1){1'b0}}};

  aff_ctl_t             c1_q, c2_q, c3_q, c4_q;
  logic                 s1_q, s2_q, s3_q, s4_q;
  logic signed [W-1:0]  e1_q [3];
  logic signed [W-1:0]  e2_q [3];
  logic signed [W-1:0]  e3_q [3];
  logic signed [W-1:0]  e4_q [3];
  logic signed [PW-1:0] pr_q [3];
  logic signed [SW-1:0] sum_q;
  logic [SW-1:0]        smag;
  logic [SW-1:0]        qm_q;
  logic [SW-1:0]        qneg;
  logic                 sneg_q;
  logic signed [W-1:0]  tr_q;

  // Magnitude of the sum; the sign is applied after rounding.
  assign smag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign qneg = -qm_q;

  // Control of all four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (adv_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // Products, sum, rounding and the saturated, negated translation.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= PW'(xl_i[k]) * PW'(ele_i[k]);
        e1_q[k] <= ele_i[k];
        e2_q[k] <= e1_q[k];
        e3_q[k] <= e2_q[k];
        e4_q[k] <= e3_q[k];
      end
      s1_q <= sing_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;

      sum_q <= SW'(pr_q[0]) + SW'(pr_q[1]) + SW'(pr_q[2]);

      sneg_q <= sum_q[SW-1];
      qm_q   <= (smag + RND) >> FRAC_BITS;

      if (sneg_q) begin
        tr_q <= (qm_q > MAXP_S) ? MAX_W : $signed(qm_q[W-1:0]);
      end else begin
        tr_q <= (qm_q > HALF_S) ? MIN_W : $signed(qneg[W-1:0]);
      end
    end
  end

  assign ctl_o  = c4_q;
  assign sing_o = s4_q;
  assign ele_o  = e4_q;
  assign tr_o   = tr_q;

endmodule

### sv/affine_matrix_inverse_3x4_core.sv
// Top level of the affine 3x4 matrix inverse core.
// Depends on aff3x4_pkg, aff3x4_seq, aff3x4_cof, aff3x4_div and aff3x4_xlat.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one 3x4 affine transform per transaction: twelve
// signed fixed-point elements (Q16.16 by default), row by row, the
// translation last in each row. The output channel gives three transactions
// per matrix, rows 0, 1 and 2 of the inverse in order, each with three
// linear elements, one translation element, a last mark on row 2 and a
// singular flag. A zero determinant sets the flag and zeroes the elements.
// Overflowing elements saturate to the word range.
// The row sequencer issues one row per cycle into a single pipeline while
// the pipeline advances, and takes a new matrix as the last row of the
// current one is issued. Each row passes through the cofactor, divider and
// translation stages to the output register; rows 1 and 2 follow row 0.
// The divider takes one quotient bit per stage and holds most of the stages.
// When the receiver stalls while a result is shown, the whole pipeline holds
// and nothing is lost; in_stall_o rises while a matrix is still being issued.
// Reset clears all valid bits; results in flight are dropped.

module affine_matrix_inverse_3x4_core #(
  parameter int WORD_BITS = aff3x4_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = aff3x4_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORD_BITS-1:0] in_r0_c0_i,
  input  logic signed [WORD_BITS-1:0] in_r0_c1_i,
  input  logic signed [WORD_BITS-1:0] in_r0_c2_i,
  input  logic signed [WORD_BITS-1:0] in_r0_t_i,
  input  logic signed [WORD_BITS-1:0] in_r1_c0_i,
  input  logic signed [WORD_BITS-1:0] in_r1_c1_i,
  input  logic signed [WORD_BITS-1:0] in_r1_c2_i,
  input  logic signed [WORD_BITS-1:0] in_r1_t_i,
  input  logic signed [WORD_BITS-1:0] in_r2_c0_i,
  input  logic signed [WORD_BITS-1:0] in_r2_c1_i,
  input  logic signed [WORD_BITS-1:0] in_r2_c2_i,
  input  logic signed [WORD_BITS-1:0] in_r2_t_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  out_row_o,
  output logic signed [WORD_BITS-1:0] out_c0_o,
  output logic signed [WORD_BITS-1:0] out_c1_o,
  output logic signed [WORD_BITS-1:0] out_c2_o,
  output logic signed [WORD_BITS-1:0] out_t_o,
  output logic                        out_last_o,
  output logic                        out_singular_o
);
  import aff3x4_pkg::*;

  localparam int W = WORD_BITS;

  logic                                adv;
  logic [NUM_ELEMS-1:0][W-1:0]         elem_in;
  logic [NUM_ELEMS-1:0][W-1:0]         elem_seq;
  aff_ctl_t                            ctl_seq, ctl_cof, ctl_div, ctl_out;
  logic signed [2*W:0]                 cof [3];
  logic signed [3*W+2:0]               det;
  logic signed [W-1:0]                 xl_cof [3];
  logic signed [W-1:0]                 xl_div [3];
  logic signed [W-1:0]                 ele_div [3];
  logic signed [W-1:0]                 ele_out [3];
  logic                                sing_div;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv = !ctl_out.vld || !out_stall_i;

  // Pack the matrix row by row.
  assign elem_in[0]  = in_r0_c0_i;
  assign elem_in[1]  = in_r0_c1_i;
  assign elem_in[2]  = in_r0_c2_i;
  assign elem_in[3]  = in_r0_t_i;
  assign elem_in[4]  = in_r1_c0_i;
  assign elem_in[5]  = in_r1_c1_i;
  assign elem_in[6]  = in_r1_c2_i;
  assign elem_in[7]  = in_r1_t_i;
  assign elem_in[8]  = in_r2_c0_i;
  assign elem_in[9]  = in_r2_c1_i;
  assign elem_in[10] = in_r2_c2_i;
  assign elem_in[11] = in_r2_t_i;

  aff3x4_seq #(.WORD_BITS(WORD_BITS)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .elem_i     (elem_in),
    .elem_o     (elem_seq),
    .ctl_o      (ctl_seq)
  );

  aff3x4_cof #(.WORD_BITS(WORD_BITS)) u_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl_seq),
    .elem_i (elem_seq),
    .ctl_o  (ctl_cof),
    .cof_o  (cof),
    .det_o  (det),
    .xl_o   (xl_cof)
  );

  aff3x4_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl_cof),
    .cof_i  (cof),
    .det_i  (det),
    .xl_i   (xl_cof),
    .ctl_o  (ctl_div),
    .sing_o (sing_div),
    .ele_o  (ele_div),
    .xl_o   (xl_div)
  );

  aff3x4_xlat #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_xlat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl_div),
    .sing_i (sing_div),
    .ele_i  (ele_div),
    .xl_i   (xl_div),
    .ctl_o  (ctl_out),
    .sing_o (out_singular_o),
    .ele_o  (ele_out),
    .tr_o   (out_t_o)
  );

  // Output transaction fields.
  assign out_valid_o = ctl_out.vld;
  assign out_row_o   = ctl_out.row;
  assign out_last_o  = (ctl_out.row == ROW_LAST);
  assign out_c0_o    = ele_out[0];
  assign out_c1_o    = ele_out[1];
  assign out_c2_o    = ele_out[2];

`ifndef SYNTH
  // Rows of one matrix leave back to back once the first is taken.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_row_o != ROW_LAST)
    |=> out_valid_o && (out_row_o == $past(out_row_o) + 2'd1))
    else $error("inverse rows out of order");

  // All rows of a matrix agree on the singular flag.
  a_sing_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_row_o != ROW_LAST)
    |=> out_singular_o == $past(out_singular_o))
    else $error("singular flag changed within a matrix");

  // A singular matrix gives all-zero elements.
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_singular_o
    |-> (out_c0_o == '0) && (out_c1_o == '0) && (out_c2_o == '0) && (out_t_o == '0))
    else $error("singular result carries nonzero elements");

  // After a matrix is taken the sequencer is busy issuing its rows.
  a_seq_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer took a matrix before issuing rows");
`endif

endmodule

### tb/affine_matrix_inverse_3x4_core_test.sv
// Testbench for the affine 3x4 matrix inverse core: directed table plus random matrices.
// Depends on aff3x4_pkg and affine_matrix_inverse_3x4_core; results are predicted in place.
`timescale 1ns / 1ps

module affine_matrix_inverse_3x4_core_test;
  import aff3x4_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = WB + 40;
  localparam int RANDOM_ITEMS = 195;
  localparam logic signed [WB-1:0] Q_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] Q_MIN = {1'b1, {(WB-1){1'b0}}};
  localparam logic signed [WB-1:0] Q_ONE = 1 <<< FB;

  typedef logic signed [WB-1:0] word_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    word_t e[NUM_ELEMS];
  } matrix_t;

  typedef struct packed {
    logic [1:0] row;
    word_t      c0, c1, c2, t;
    logic       last, singular;
  } inv_row_t;

  // Directed row: matrix plus a typed-in row 0 when it can be read at a glance.
  typedef struct {
    matrix_t  m;
    logic     has_golden;
    inv_row_t golden;
  } directed_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  word_t in_e[NUM_ELEMS];
  logic [1:0] out_row;
  word_t out_c0, out_c1, out_c2, out_t;
  logic out_last, out_singular;

  inv_row_t expected_rows[$];
  directed_t directed[$];
  int mismatches = 0;
  int rows_checked = 0;
  int singular_seen = 0;
  int matrices_sent = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  affine_matrix_inverse_3x4_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_r0_c0_i(in_e[0]), .in_r0_c1_i(in_e[1]), .in_r0_c2_i(in_e[2]), .in_r0_t_i(in_e[3]),
    .in_r1_c0_i(in_e[4]), .in_r1_c1_i(in_e[5]), .in_r1_c2_i(in_e[6]), .in_r1_t_i(in_e[7]),
    .in_r2_c0_i(in_e[8]), .in_r2_c1_i(in_e[9]), .in_r2_c2_i(in_e[10]), .in_r2_t_i(in_e[11]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_row_o(out_row), .out_c0_o(out_c0), .out_c1_o(out_c1), .out_c2_o(out_c2),
    .out_t_o(out_t), .out_last_o(out_last), .out_singular_o(out_singular)
  );

  // Clock generation.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Division rounded to nearest, ties away from zero.
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t an, ad, q, r;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = an / ad;
    r = an % ad;
    if (2 * r >= ad) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic word_t clamp_word(wide_t x);
    if (x > wide_t'(Q_MAX)) return Q_MAX;
    if (x < wide_t'(Q_MIN)) return Q_MIN;
    return word_t'(x);
  endfunction

  // Inverse of one affine matrix as three expected rows.
  function automatic void predict_inverse(matrix_t m, ref inv_row_t rows[3]);
    wide_t a[3][3], tv[3], cof[3][3], det, s;
    word_t lin[3][3];
    int i, j, i1, i2, j1, j2;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) a[i][j] = m.e[4*i+j];
      tv[i] = m.e[4*i+3];
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3; i2 = (i + 2) % 3; j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        cof[i][j] = a[j1][i1] * a[j2][i2] - a[j1][i2] * a[j2][i1];
      end
    det = a[0][0] * cof[0][0] + a[0][1] * cof[1][0] + a[0][2] * cof[2][0];
    for (i = 0; i < 3; i++) begin
      rows[i].row = 2'(i);
      rows[i].last = (i == 2);
      rows[i].singular = (det == 0);
      rows[i].t = '0;
      for (j = 0; j < 3; j++)
        lin[i][j] = (det == 0) ? word_t'(0) : clamp_word(round_div(cof[i][j] <<< (2*FB), det));
      if (det != 0) begin
        s = tv[0] * wide_t'(lin[i][0]) + tv[1] * wide_t'(lin[i][1])
          + tv[2] * wide_t'(lin[i][2]);
        rows[i].t = clamp_word(-round_div(s, wide_t'(1) <<< FB));
      end
      rows[i].c0 = lin[i][0]; rows[i].c1 = lin[i][1]; rows[i].c2 = lin[i][2];
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  function automatic matrix_t diag_matrix(word_t d0, word_t d1, word_t d2);
    matrix_t m;
    foreach (m.e[k]) m.e[k] = '0;
    m.e[0] = d0; m.e[5] = d1; m.e[10] = d2;
    return m;
  endfunction

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      2: return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
      default: return word_t'($urandom_range(0, 3)) - 1;
    endcase
  endfunction

  // Random matrices: mostly well-conditioned, some extreme, some singular.
  function automatic matrix_t rand_matrix();
    matrix_t m;
    int kind, mode;
    kind = $urandom_range(0, 9);
    foreach (m.e[k]) begin
      mode = (kind < 5) ? 1 : (kind < 7) ? 0 : (kind == 7) ? $urandom_range(0, 3) : 3;
      m.e[k] = rand_word(mode);
    end
    if (kind < 3) begin
      m.e[0] += Q_ONE <<< 3; m.e[5] += Q_ONE <<< 3; m.e[10] += Q_ONE <<< 3;
    end
    // Force a singular matrix by copying one row into another.
    if (kind == 9) begin
      m.e[8] = m.e[0]; m.e[9] = m.e[1]; m.e[10] = m.e[2];
    end
    return m;
  endfunction

  task automatic build_directed();
    directed_t d;
    d.has_golden = 0;
    // Identity gives identity with zero translation.
    d.m = diag_matrix(Q_ONE, Q_ONE, Q_ONE);
    d.has_golden = 1;
    d.golden = '{row: ROW_FIRST, c0: Q_ONE, c1: 0, c2: 0, t: 0, last: 0, singular: 0};
    directed.push_back(d);
    // Identity with translation: inverse translation is negated.
    d.m.e[3] = Q_ONE * 5; d.m.e[7] = -Q_ONE; d.m.e[11] = Q_MAX;
    d.golden.t = -(Q_ONE * 5);
    directed.push_back(d);
    // All zero matrix is singular.
    d.m = diag_matrix(0, 0, 0);
    d.golden = '{row: ROW_FIRST, c0: 0, c1: 0, c2: 0, t: 0, last: 0, singular: 1};
    directed.push_back(d);
    // Singular with extreme translation; elements still zero.
    d.m = diag_matrix(Q_ONE, 0, Q_ONE);
    d.m.e[3] = Q_MIN; d.m.e[7] = Q_MAX; d.m.e[11] = Q_MIN;
    directed.push_back(d);
    d.has_golden = 0;
    // Tiny diagonal overflows and saturates.
    d.m = diag_matrix(1, 1, 1);
    d.has_golden = 1;
    d.golden = '{row: ROW_FIRST, c0: Q_MAX, c1: 0, c2: 0, t: 0, last: 0, singular: 0};
    directed.push_back(d);
    d.m = diag_matrix(-1, 1, 1);
    d.golden.c0 = Q_MIN;
    directed.push_back(d);
    d.has_golden = 0;
    // Extreme elements on the diagonal, then in every position.
    d.m = diag_matrix(Q_MAX, Q_MAX, Q_MAX); directed.push_back(d);
    d.m = diag_matrix(Q_MIN, Q_MIN, Q_MIN); directed.push_back(d);
    d.m = diag_matrix(Q_MIN, Q_MAX, Q_MIN);
    d.m.e[3] = Q_MAX; d.m.e[7] = Q_MIN; d.m.e[11] = Q_MAX; directed.push_back(d);
    foreach (d.m.e[k]) d.m.e[k] = Q_MAX;
    directed.push_back(d);
    foreach (d.m.e[k]) d.m.e[k] = Q_MIN;
    directed.push_back(d);
    foreach (d.m.e[k]) d.m.e[k] = (k % 2) ? Q_MIN : Q_MAX;
    directed.push_back(d);
    foreach (d.m.e[k]) d.m.e[k] = -1;
    directed.push_back(d);
    // Permutation and scaled matrices.
    d.m = diag_matrix(0, 0, 0);
    d.m.e[1] = Q_ONE; d.m.e[6] = Q_ONE * 2; d.m.e[8] = -Q_ONE;
    d.m.e[3] = 7; d.m.e[7] = -3; d.m.e[11] = Q_ONE;
    directed.push_back(d);
    d.m = diag_matrix(Q_ONE * 3, Q_ONE / 2, -Q_ONE * 4);
    d.m.e[3] = Q_ONE; d.m.e[7] = Q_ONE; d.m.e[11] = Q_ONE;
    directed.push_back(d);
    // Rounding ties: 1/3 style divisions.
    d.m = diag_matrix(Q_ONE * 3, Q_ONE * 3, -Q_ONE * 3);
    d.m.e[3] = 1; d.m.e[7] = -1; d.m.e[11] = 3;
    directed.push_back(d);
  endtask

  // Input driver: directed table, then random matrices; random gaps.
  task automatic send_matrix(matrix_t m);
    inv_row_t rows[3];
    // Random idle cycles, except in the stretch with no idling on the input side.
    if (!(matrices_sent > 60 && matrices_sent < 130)) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    foreach (in_e[k]) in_e[k] <= m.e[k];
    predict_inverse(m, rows);
    for (int k = 0; k < 3; k++) expected_rows.push_back(rows[k]);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    matrices_sent++;
  endtask

  initial begin
    inv_row_t rows[3];
    matrix_t m;
    rst_n = 0;
    in_valid = 0;
    foreach (in_e[k]) in_e[k] = '0;
    build_directed();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[n]) begin
      if (directed[n].has_golden) begin
        predict_inverse(directed[n].m, rows);
        if (rows[0] != directed[n].golden)
          report_mismatch($sformatf("table entry %0d row 0 {c0,t}", n),
                          {rows[0].c0, rows[0].t},
                          {directed[n].golden.c0, directed[n].golden.t});
      end
      send_matrix(directed[n].m);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      m = rand_matrix();
      send_matrix(m);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver stall: random, with one long hold-off to fill the pipeline.
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (matrices_sent == 30 && !hold_off) begin
        hold_off = 1;
        out_stall <= 1;
        repeat (150) @(posedge clk);
      end
      if (matrices_sent > 60 && matrices_sent < 130) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < 23);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    inv_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result row", 64'(out_row), 64'(0));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (out_singular) singular_seen++;
        if (out_row != want.row) report_mismatch("row", out_row, want.row);
        if (out_c0 != want.c0) report_mismatch("c0", out_c0, want.c0);
        if (out_c1 != want.c1) report_mismatch("c1", out_c1, want.c1);
        if (out_c2 != want.c2) report_mismatch("c2", out_c2, want.c2);
        if (out_t != want.t) report_mismatch("t", out_t, want.t);
        if (out_last != want.last) report_mismatch("last", out_last, want.last);
        if (out_singular != want.singular)
          report_mismatch("singular", out_singular, want.singular);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d rows outstanding", expected_rows.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d matrices, checked %0d inverse rows, %0d singular rows seen.",
             matrices_sent, rows_checked, singular_seen);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/aff3x4_pkg.sv
sv/aff3x4_seq.sv
sv/aff3x4_cof.sv
sv/aff3x4_div.sv
sv/aff3x4_xlat.sv
sv/affine_matrix_inverse_3x4_core.sv
tb/affine_matrix_inverse_3x4_core_test.sv
